### hw/rtl/ipdd_pkg.sv
// ----------------------------------------------------------------------------
// ipdd_pkg: shared types and constants
// Payload structs, configuration register set and register indexes for the
// pulse-distance infrared decoder.
// ----------------------------------------------------------------------------
package ipdd_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned TICK_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LEAD_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LEAD_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_LEAD_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_LEAD_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MAX         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESHOLD   = 3'd5;

    // Reset values
    localparam logic [TICK_W-1:0] RST_NORMAL_LEAD_MIN = 8'd100;
    localparam logic [TICK_W-1:0] RST_NORMAL_LEAD_MAX = 8'd110;
    localparam logic [TICK_W-1:0] RST_REPEAT_LEAD_MIN = 8'd83;
    localparam logic [TICK_W-1:0] RST_REPEAT_LEAD_MAX = 8'd93;
    localparam logic [TICK_W-1:0] RST_BIT_MAX         = 8'd20;
    localparam logic [TICK_W-1:0] RST_BIT_THRESHOLD   = 8'd13;

    typedef struct packed {
        logic [TICK_W-1:0] interval;
        logic              timer_overflow;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] code_word;
        logic              is_repeat;
    } t_out;

    typedef struct packed {
        logic [TICK_W-1:0] normal_lead_min;
        logic [TICK_W-1:0] normal_lead_max;
        logic [TICK_W-1:0] repeat_lead_min;
        logic [TICK_W-1:0] repeat_lead_max;
        logic [TICK_W-1:0] bit_max;
        logic [TICK_W-1:0] bit_threshold;
    } t_cfg;

endpackage

### hw/rtl/ipdd_cfg_regs.sv
// ----------------------------------------------------------------------------
// ipdd_cfg_regs: configuration register file
// Six 8-bit timing registers written through a plain write port; writes to
// an unused index are dropped.
// ----------------------------------------------------------------------------
module ipdd_cfg_regs
    import ipdd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_lead_min <= RST_NORMAL_LEAD_MIN;
            r_cfg.normal_lead_max <= RST_NORMAL_LEAD_MAX;
            r_cfg.repeat_lead_min <= RST_REPEAT_LEAD_MIN;
            r_cfg.repeat_lead_max <= RST_REPEAT_LEAD_MAX;
            r_cfg.bit_max         <= RST_BIT_MAX;
            r_cfg.bit_threshold   <= RST_BIT_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NORMAL_LEAD_MIN: r_cfg.normal_lead_min <= i_cfg_data;
                REG_NORMAL_LEAD_MAX: r_cfg.normal_lead_max <= i_cfg_data;
                REG_REPEAT_LEAD_MIN: r_cfg.repeat_lead_min <= i_cfg_data;
                REG_REPEAT_LEAD_MAX: r_cfg.repeat_lead_max <= i_cfg_data;
                REG_BIT_MAX:         r_cfg.bit_max         <= i_cfg_data;
                REG_BIT_THRESHOLD:   r_cfg.bit_threshold   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/ir_pulse_distance_decoder_top.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_top: pulse-distance infrared frame decoder
// Takes one falling-edge interval per beat, tracks lead / data bits and
// emits the received word on frame end or on a repeat lead.
// ----------------------------------------------------------------------------
// Path: a result passes through the input register, then the result
//   register, before it is shown on o_out.
// Throughput: one input beat per cycle; the input side stalls only while a
//   held result is stalled and the input register is full.
// Reset (synchronous, active low): idle awaiting a lead, saved word zero,
//   timing registers at their default values, both stages empty.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder_top
    import ipdd_pkg::*;
#(
    parameter int unsigned FRAME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out
);

    localparam int unsigned CNT_W = $clog2(FRAME_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_IDLE = CNT_W'(FRAME_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BITS - 1);

    t_cfg w_cfg;

    ipdd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    logic              r_in_valid;
    t_in               r_in;
    logic              r_out_valid;
    t_out              r_out;
    logic [CNT_W-1:0]  r_bits;
    logic [WORD_W-1:0] r_word;

    logic              n_out_valid;
    t_out              n_out;
    logic [CNT_W-1:0]  n_bits;
    logic [WORD_W-1:0] n_word;

    logic out_free;
    logic proc;
    logic in_take;
    logic idle;
    logic in_normal;
    logic in_repeat;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign idle      = (r_bits >= CNT_IDLE);
    assign in_normal = (r_in.interval > w_cfg.normal_lead_min) &&
                       (r_in.interval < w_cfg.normal_lead_max);
    assign in_repeat = (r_in.interval > w_cfg.repeat_lead_min) &&
                       (r_in.interval < w_cfg.repeat_lead_max);

    always_comb begin
        n_bits          = r_bits;
        n_word          = r_word;
        n_out_valid     = 1'b0;
        n_out.code_word = r_word;
        n_out.is_repeat = 1'b0;
        if (idle) begin
            // overflow while idle drops the edge
            if (!r_in.timer_overflow) begin
                if (in_normal) begin
                    n_word = '0;
                    n_bits = '0;
                end else if (in_repeat) begin
                    n_out_valid     = 1'b1;
                    n_out.is_repeat = 1'b1;
                end
            end
        end else if (r_in.timer_overflow || (r_in.interval > w_cfg.bit_max)) begin
            // abort: keep the partial word
            n_bits = CNT_IDLE;
        end else begin
            n_word = {r_word[WORD_W-2:0], (r_in.interval > w_cfg.bit_threshold)};
            n_bits = r_bits + 1'b1;
            if (r_bits == CNT_LAST) begin
                n_out_valid     = 1'b1;
                n_out.code_word = n_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_bits      <= CNT_IDLE;
            r_word      <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_bits      <= n_bits;
                r_word      <= n_word;
                r_out_valid <= n_out_valid;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
        if (proc && n_out_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= CNT_IDLE)
        else $error("bit count beyond frame length");

    a_frame_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && !idle && !r_in.timer_overflow && (r_in.interval <= w_cfg.bit_max)
         && (r_bits == CNT_LAST))
        |=> (o_out_valid && !o_out.is_repeat && (r_bits == CNT_IDLE)))
        else $error("completed frame not emitted");

    a_lead_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && idle && !r_in.timer_overflow && in_normal)
        |=> ((r_bits == '0) && (r_word == '0) && !o_out_valid))
        else $error("normal lead did not start a frame");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with nothing held");

endmodule
